@@ hw/rtl/block_buffer_cache_manager_assert.svh @@
// Assertion macros shared by the buffer cache manager RTL.
`ifndef BLOCK_BUFFER_CACHE_MANAGER_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BBCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BBCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bbcm_pkg.sv @@
// Types and constants of the buffer cache manager.
`default_nettype none
package bbcm_pkg;

	localparam int NUM_SLOTS         = 64;
	localparam int SECTORS_PER_BLOCK = 2;
	localparam int SLOT_W            = $clog2(NUM_SLOTS);
	localparam int CNT_W             = $clog2(NUM_SLOTS + 1);
	localparam int DEV_W             = 8;
	localparam int BLK_W             = 32;
	localparam int TAG_W             = DEV_W + BLK_W;
	localparam int REF_W             = 8;
	localparam int SECTOR_W          = 33;

	typedef enum logic [1:0] {
		CMD_READ      = 2'd0,
		CMD_RELEASE   = 2'd1,
		CMD_WRITEBACK = 2'd2,
		CMD_MARK      = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		STS_HIT     = 4'd0,
		STS_MISS    = 4'd1,
		STS_NOBUF   = 4'd2,
		STS_HELD    = 4'd3,
		STS_FREED   = 4'd4,
		STS_ERROR   = 4'd5,
		STS_WRITTEN = 4'd6,
		STS_CLEAN   = 4'd7,
		STS_MARKED  = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		IO_NONE  = 2'd0,
		IO_READ  = 2'd1,
		IO_WRITE = 2'd2
	} io_t;

	typedef enum logic [1:0] {RD_IDX, RD_SLOT, RD_HEAD} rd_sel_t;
	typedef enum logic [1:0] {TGT_SLOT, TGT_IDX, TGT_HANDED, TGT_HEAD} tgt_sel_t;
	typedef enum logic [1:0] {CW_INC, CW_ONE, CW_DEC} cnt_op_t;
	typedef enum logic [1:0] {RS_ZERO, RS_IDX, RS_SLOT, RS_TGT} rslot_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SCAN_RD, ST_SCAN_CMP, ST_MISS, ST_UNLINK_HIT,
		ST_UNLINK_EVICT, ST_FILL, ST_SLOT_RD, ST_SLOT_OP, ST_PUSH, ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       ld_in;
		logic       idx_clr;
		logic       idx_inc;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       tgt_ld;
		tgt_sel_t   tgt_sel;
		logic       handed_inc;
		logic       fill;
		logic       cnt_wr;
		cnt_op_t    cnt_op;
		logic       unlink;
		logic       push;
		logic       dirty_set;
		logic       dirty_clr;
		logic       res_ld;
		status_t    res_status;
		rslot_sel_t res_slot_sel;
		io_t        res_io;
		logic       res_wake;
		logic       out_ld;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic match;
		logic cnt_full;
		logic cnt_zero;
		logic cnt_one;
		logic dirty;
		logic is_free;
		logic handed_zero;
		logic handed_full;
		logic free_empty;
		logic slot_oob;
		logic idx_last;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/block_buffer_cache_manager.sv @@
// Top level of the block buffer cache manager.
// A read compares the tags of the slots handed out so far, one after another.
// One item is in work at a time; the next is accepted in the cycle after its result is loaded.
// Reset is asynchronous active low; it empties the free list and hands out no slot.
`default_nettype none
module block_buffer_cache_manager import bbcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [DEV_W-1:0]    device,
	input  logic [BLK_W-1:0]    block_number,
	input  logic [SLOT_W-1:0]   slot,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          status,
	output logic [SLOT_W-1:0]   result_slot,
	output logic [1:0]          io_request,
	output logic [DEV_W-1:0]    io_device,
	output logic [SECTOR_W-1:0] io_sector,
	output logic                wake_waiter
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Sequencing of each item.
	bbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (stat),
		.c         (ctl)
	);

	// Slot state, free list and result registers.
	bbcm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.device       (device),
		.block_number (block_number),
		.slot         (slot),
		.c            (ctl),
		.st           (stat),
		.status       (status),
		.result_slot  (result_slot),
		.io_request   (io_request),
		.io_device    (io_device),
		.io_sector    (io_sector),
		.wake_waiter  (wake_waiter)
	);

endmodule
`default_nettype wire

@@ hw/rtl/bbcm_dp.sv @@
// Datapath of the buffer cache manager: tag, count and free list memories.
`default_nettype none
module bbcm_dp import bbcm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          cmd,
	input  logic [DEV_W-1:0]    device,
	input  logic [BLK_W-1:0]    block_number,
	input  logic [SLOT_W-1:0]   slot,
	input  ctl_cmd_t            c,
	output dp_stat_t            st,
	output logic [3:0]          status,
	output logic [SLOT_W-1:0]   result_slot,
	output logic [1:0]          io_request,
	output logic [DEV_W-1:0]    io_device,
	output logic [SECTOR_W-1:0] io_sector,
	output logic                wake_waiter
);

	localparam logic [SECTOR_W-1:0] SPB = SECTOR_W'(SECTORS_PER_BLOCK);

	cmd_t                cmd_q;
	logic [DEV_W-1:0]    dev_q;
	logic [BLK_W-1:0]    blk_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   tgt_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    handed_q;
	logic [CNT_W-1:0]    free_len_q;
	logic [NUM_SLOTS-1:0] dirty_q;
	logic [NUM_SLOTS-1:0] free_q;

	logic [TAG_W-1:0]    tag_mem  [NUM_SLOTS];
	logic [REF_W-1:0]    cnt_mem  [NUM_SLOTS];
	logic [SLOT_W-1:0]   next_mem [NUM_SLOTS];
	logic [SLOT_W-1:0]   prev_mem [NUM_SLOTS];

	logic [TAG_W-1:0]    rtag_q;
	logic [REF_W-1:0]    rcnt_q;
	logic [SLOT_W-1:0]   rnext_q;
	logic [SLOT_W-1:0]   rprev_q;

	logic [3:0]          res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [1:0]          res_io_q;
	logic [DEV_W-1:0]    res_dev_q;
	logic [SECTOR_W-1:0] res_sec_q;
	logic                res_wake_q;

	logic [SLOT_W-1:0]   rd_addr;
	logic [SLOT_W-1:0]   tgt_d;
	logic [SLOT_W-1:0]   cnt_addr;
	logic [REF_W-1:0]    cnt_data;
	logic                nx_we;
	logic [SLOT_W-1:0]   nx_addr;
	logic [SLOT_W-1:0]   nx_data;
	logic                pv_we;
	logic [SLOT_W-1:0]   pv_addr;
	logic [SLOT_W-1:0]   pv_data;
	logic [SLOT_W-1:0]   rslot_d;
	logic [DEV_W-1:0]    iodev_d;
	logic [BLK_W-1:0]    ioblk_d;

	// Input item capture and scan index.
	always_ff @(posedge clk) begin
		if (c.ld_in) begin
			cmd_q  <= cmd_t'(cmd);
			dev_q  <= device;
			blk_q  <= block_number;
			slot_q <= slot;
		end
		if (c.idx_clr) begin
			idx_q <= '0;
		end else if (c.idx_inc) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
		if (c.tgt_ld) begin
			tgt_q <= tgt_d;
		end
	end

	always_comb begin
		unique case (c.tgt_sel)
			TGT_SLOT:   tgt_d = slot_q;
			TGT_IDX:    tgt_d = idx_q;
			TGT_HANDED: tgt_d = handed_q[SLOT_W-1:0];
			TGT_HEAD:   tgt_d = head_q;
			default:    tgt_d = slot_q;
		endcase
	end

	// Shared read address for all slot memories.
	always_comb begin
		unique case (c.rd_sel)
			RD_IDX:  rd_addr = idx_q;
			RD_SLOT: rd_addr = slot_q;
			RD_HEAD: rd_addr = head_q;
			default: rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (c.rd_en) begin
			rtag_q  <= tag_mem[rd_addr];
			rcnt_q  <= cnt_mem[rd_addr];
			rnext_q <= next_mem[rd_addr];
			rprev_q <= prev_mem[rd_addr];
		end
	end

	// Reference count write port.
	always_comb begin
		unique case (c.cnt_op)
			CW_INC: begin
				cnt_addr = idx_q;
				cnt_data = rcnt_q + REF_W'(1);
			end
			CW_ONE: begin
				cnt_addr = tgt_q;
				cnt_data = REF_W'(1);
			end
			CW_DEC: begin
				cnt_addr = tgt_q;
				cnt_data = rcnt_q - REF_W'(1);
			end
			default: begin
				cnt_addr = tgt_q;
				cnt_data = rcnt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (c.cnt_wr) begin
			cnt_mem[cnt_addr] <= cnt_data;
		end
		if (c.fill) begin
			tag_mem[tgt_q] <= {dev_q, blk_q};
		end
	end

	// Free list link writes: unlink the target or append it at the tail.
	always_comb begin
		nx_we   = 1'b0;
		nx_addr = rprev_q;
		nx_data = rnext_q;
		pv_we   = 1'b0;
		pv_addr = rnext_q;
		pv_data = rprev_q;
		if (c.unlink) begin
			nx_we = (tgt_q != head_q);
			pv_we = (tgt_q != tail_q);
		end else if (c.push && (free_len_q != '0)) begin
			nx_we   = 1'b1;
			nx_addr = tail_q;
			nx_data = tgt_q;
			pv_we   = 1'b1;
			pv_addr = tgt_q;
			pv_data = tail_q;
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_addr] <= nx_data;
		end
		if (pv_we) begin
			prev_mem[pv_addr] <= pv_data;
		end
	end

	// Free list ends, counters and per-slot flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			free_len_q <= '0;
			handed_q   <= '0;
			dirty_q    <= '0;
			free_q     <= '0;
		end else begin
			if (c.unlink) begin
				if (tgt_q == head_q) head_q <= rnext_q;
				if (tgt_q == tail_q) tail_q <= rprev_q;
				free_len_q     <= free_len_q - CNT_W'(1);
				free_q[tgt_q]  <= 1'b0;
			end else if (c.push) begin
				if (free_len_q == '0) head_q <= tgt_q;
				tail_q         <= tgt_q;
				free_len_q     <= free_len_q + CNT_W'(1);
				free_q[tgt_q]  <= 1'b1;
			end
			if (c.handed_inc) begin
				handed_q <= handed_q + CNT_W'(1);
			end
			if (c.dirty_set) begin
				dirty_q[tgt_q] <= 1'b1;
			end else if (c.dirty_clr) begin
				dirty_q[tgt_q] <= 1'b0;
			end
		end
	end

	// Result fields.
	always_comb begin
		unique case (c.res_slot_sel)
			RS_ZERO: rslot_d = '0;
			RS_IDX:  rslot_d = idx_q;
			RS_SLOT: rslot_d = slot_q;
			RS_TGT:  rslot_d = tgt_q;
			default: rslot_d = '0;
		endcase
		if (c.res_io == IO_READ) begin
			iodev_d = dev_q;
			ioblk_d = blk_q;
		end else if (c.res_io == IO_WRITE) begin
			iodev_d = rtag_q[TAG_W-1:BLK_W];
			ioblk_d = rtag_q[BLK_W-1:0];
		end else begin
			iodev_d = '0;
			ioblk_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.res_ld) begin
			res_status_q <= c.res_status;
			res_slot_q   <= rslot_d;
			res_io_q     <= c.res_io;
			res_dev_q    <= iodev_d;
			res_sec_q    <= SECTOR_W'(ioblk_d) * SPB;
			res_wake_q   <= c.res_wake;
		end
		if (c.out_ld) begin
			status      <= res_status_q;
			result_slot <= res_slot_q;
			io_request  <= res_io_q;
			io_device   <= res_dev_q;
			io_sector   <= res_sec_q;
			wake_waiter <= res_wake_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		st.cmd         = cmd_q;
		st.match       = (rtag_q == {dev_q, blk_q});
		st.cnt_full    = (rcnt_q == '1);
		st.cnt_zero    = (rcnt_q == '0);
		st.cnt_one     = (rcnt_q == REF_W'(1));
		st.dirty       = dirty_q[tgt_q];
		st.is_free     = free_q[idx_q];
		st.handed_zero = (handed_q == '0);
		st.handed_full = (handed_q == CNT_W'(NUM_SLOTS));
		st.free_empty  = (free_len_q == '0);
		st.slot_oob    = (CNT_W'(slot_q) >= handed_q);
		st.idx_last    = ((CNT_W'(idx_q) + CNT_W'(1)) == handed_q);
	end

endmodule
`default_nettype wire

@@ hw/rtl/bbcm_ctrl.sv @@
// Controller state machine of the buffer cache manager.
`default_nettype none
`include "block_buffer_cache_manager_assert.svh"
module bbcm_ctrl import bbcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t st,
	output ctl_cmd_t c
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_room;

	assign out_room  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (c.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (st.cmd == CMD_READ) begin
					state_d = st.handed_zero ? ST_MISS : ST_SCAN_RD;
				end else begin
					state_d = st.slot_oob ? ST_FINISH : ST_SLOT_RD;
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (st.match) begin
					state_d = (!st.cnt_full && st.is_free) ? ST_UNLINK_HIT : ST_FINISH;
				end else begin
					state_d = st.idx_last ? ST_MISS : ST_SCAN_RD;
				end
			end
			ST_MISS: begin
				if (!st.handed_full) state_d = ST_FILL;
				else if (!st.free_empty) state_d = ST_UNLINK_EVICT;
				else state_d = ST_FINISH;
			end
			ST_UNLINK_HIT:   state_d = ST_FINISH;
			ST_UNLINK_EVICT: state_d = ST_FILL;
			ST_FILL:         state_d = ST_FINISH;
			ST_SLOT_RD:      state_d = ST_SLOT_OP;
			ST_SLOT_OP: begin
				if (st.cmd == CMD_RELEASE && !st.cnt_zero && st.cnt_one) begin
					state_d = ST_PUSH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_PUSH:   state_d = ST_FINISH;
			ST_FINISH: if (out_room) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		c = '0;
		unique case (state_q)
			ST_IDLE: c.ld_in = in_valid;
			ST_CHECK: begin
				if (st.cmd == CMD_READ) begin
					c.idx_clr = 1'b1;
				end else if (st.slot_oob) begin
					c.res_ld       = 1'b1;
					c.res_status   = STS_ERROR;
					c.res_slot_sel = RS_SLOT;
				end else begin
					c.tgt_ld  = 1'b1;
					c.tgt_sel = TGT_SLOT;
				end
			end
			ST_SCAN_RD: begin
				c.rd_en  = 1'b1;
				c.rd_sel = RD_IDX;
			end
			ST_SCAN_CMP: begin
				if (st.match) begin
					c.res_ld       = 1'b1;
					c.res_slot_sel = RS_IDX;
					if (st.cnt_full) begin
						c.res_status = STS_ERROR;
					end else begin
						c.res_status = STS_HIT;
						c.cnt_wr     = 1'b1;
						c.cnt_op     = CW_INC;
						c.tgt_ld     = 1'b1;
						c.tgt_sel    = TGT_IDX;
					end
				end else begin
					c.idx_inc = !st.idx_last;
				end
			end
			ST_MISS: begin
				if (!st.handed_full) begin
					c.tgt_ld     = 1'b1;
					c.tgt_sel    = TGT_HANDED;
					c.handed_inc = 1'b1;
				end else if (!st.free_empty) begin
					c.tgt_ld  = 1'b1;
					c.tgt_sel = TGT_HEAD;
					c.rd_en   = 1'b1;
					c.rd_sel  = RD_HEAD;
				end else begin
					c.res_ld       = 1'b1;
					c.res_status   = STS_NOBUF;
					c.res_slot_sel = RS_ZERO;
				end
			end
			ST_UNLINK_HIT:   c.unlink = 1'b1;
			ST_UNLINK_EVICT: c.unlink = 1'b1;
			ST_FILL: begin
				c.fill         = 1'b1;
				c.cnt_wr       = 1'b1;
				c.cnt_op       = CW_ONE;
				c.dirty_clr    = 1'b1;
				c.res_ld       = 1'b1;
				c.res_status   = STS_MISS;
				c.res_slot_sel = RS_TGT;
				c.res_io       = IO_READ;
			end
			ST_SLOT_RD: begin
				c.rd_en  = 1'b1;
				c.rd_sel = RD_SLOT;
			end
			ST_SLOT_OP: begin
				c.res_ld       = 1'b1;
				c.res_slot_sel = RS_SLOT;
				c.res_status   = STS_ERROR;
				unique case (st.cmd)
					CMD_RELEASE: begin
						if (!st.cnt_zero) begin
							c.cnt_wr = 1'b1;
							c.cnt_op = CW_DEC;
							if (st.cnt_one) begin
								c.res_status = STS_FREED;
								c.res_wake   = 1'b1;
								c.res_io     = st.dirty ? IO_WRITE : IO_NONE;
								c.dirty_clr  = 1'b1;
							end else begin
								c.res_status = STS_HELD;
							end
						end
					end
					CMD_WRITEBACK: begin
						if (st.dirty) begin
							c.res_status = STS_WRITTEN;
							c.res_io     = IO_WRITE;
							c.dirty_clr  = 1'b1;
						end else begin
							c.res_status = STS_CLEAN;
						end
					end
					CMD_MARK: begin
						if (!st.cnt_zero) begin
							c.res_status = STS_MARKED;
							c.dirty_set  = 1'b1;
						end
					end
					default: c.res_status = STS_ERROR;
				endcase
			end
			ST_PUSH:   c.push   = 1'b1;
			ST_FINISH: c.out_ld = out_room;
			default:   c.ld_in  = 1'b0;
		endcase
	end

	`BBCM_ASSERT_NXT(a_accept_check, in_valid && !in_stall, state_q == ST_CHECK, "accepted item did not enter check")
	`BBCM_ASSERT_NOW(a_out_room, c.out_ld, !out_valid_q || !out_stall, "result overwrote a waiting item")
	`BBCM_ASSERT_NOW(a_push_after_op, state_q == ST_PUSH, $past(state_q) == ST_SLOT_OP, "free list push outside release")
	`BBCM_ASSERT_NOW(a_one_link_op, c.unlink, !c.push, "unlink and push in one cycle")

endmodule
`default_nettype wire
